[rtl/ifpxc_pkg.sv]
// Shared types and constants for the IMU frame parser with XOR check.
// No dependencies; used by every module in rtl/.
package ifpxc_pkg;

  // Frame geometry
  localparam int FRAME_BYTES  = 22;
  localparam int FILL_W       = $clog2(FRAME_BYTES);
  localparam int SAMPLE_COUNT = 10;
  localparam int ACCEL_END    = 3;
  localparam int GYRO_END     = 6;
  localparam int RESULT_W     = 32;

  // Configuration register indexes
  localparam logic [7:0] CFG_HEADER = 8'd0;
  localparam logic [7:0] CFG_ACCEL  = 8'd1;
  localparam logic [7:0] CFG_GYRO   = 8'd2;
  localparam logic [7:0] CFG_QUAT   = 8'd3;

  // Result status codes
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // Group gains, unsigned Q0.16
  typedef struct packed {
    logic [15:0] quat;
    logic [15:0] gyro;
    logic [15:0] accel;
  } gains_t;

  // One finished frame from the framer to the scaler
  typedef struct packed {
    logic                               status;
    logic [SAMPLE_COUNT-1:0][15:0]      raw;
  } frame_t;

endpackage

[rtl/imu_frame_parser_xor_check_unit.sv]
// Top level of the IMU frame parser with header sync and XOR checksum.
// Depends on ifpxc_pkg, ifpxc_framer and ifpxc_scaler.
//
//  channel  | ports        | payload
//  ---------+--------------+-----------------------------------------------
//  input    | in_t*        | tdata[7:0] rx_byte
//  result   | out_t*       | tdata: 10 x 32-bit Q16.16 samples, tuser status
//  config   | cfg_*        | cfg_index register, cfg_data value (always ready)
//
// One byte is taken per cycle while in_tready is high. A completed frame passes
// through the framer's frame register, then the multipliers' result register.
// Reset (synchronous, rst_n low) empties the frame store and both stages and
// zeroes the configuration registers; data registers are not reset.
// A stalled output holds its word; input keeps flowing
// until both the frame register and the result register are occupied.
module imu_frame_parser_xor_check_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
  // quat_x, quat_y, quat_z, [319:288] quat_w
  output logic [319:0] out_tdata,
  output logic         out_tuser,  // [0] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [7:0]         header_r;
  ifpxc_pkg::gains_t  gains_r;
  logic               frame_valid;
  logic               frame_ready;
  ifpxc_pkg::frame_t  frame_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      gains_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ifpxc_pkg::CFG_HEADER: header_r      <= cfg_data[7:0];
        ifpxc_pkg::CFG_ACCEL:  gains_r.accel <= cfg_data;
        ifpxc_pkg::CFG_GYRO:   gains_r.gyro  <= cfg_data;
        ifpxc_pkg::CFG_QUAT:   gains_r.quat  <= cfg_data;
        default: ;
      endcase
    end
  end

  ifpxc_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (in_tvalid),
    .byte_ready   (in_tready),
    .byte_data    (in_tdata),
    .header_value (header_r),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_data   (frame_data)
  );

  ifpxc_scaler u_scaler (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_data   (frame_data),
    .gains        (gains_r),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_data     (out_tdata),
    .res_status   (out_tuser)
  );

endmodule

[rtl/ifpxc_framer.sv]
// Byte framer: header sync, frame store, running XOR and checksum decision.
// Depends on ifpxc_pkg. Emits one registered frame_t per completed frame.
module ifpxc_framer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  logic [7:0]            byte_data,
  input  logic [7:0]            header_value,
  output logic                  frame_valid,
  input  logic                  frame_ready,
  output ifpxc_pkg::frame_t     frame_data
);

  localparam logic [ifpxc_pkg::FILL_W-1:0] LAST_IDX =
    ifpxc_pkg::FILL_W'(ifpxc_pkg::FRAME_BYTES - 1);

  logic [7:0]                    store_r   [ifpxc_pkg::FRAME_BYTES];
  logic [7:0]                    store_nxt [ifpxc_pkg::FRAME_BYTES];
  logic [7:0]                    wr_store  [ifpxc_pkg::FRAME_BYTES];
  logic [ifpxc_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [7:0]                    xor_r, xor_nxt;
  logic                          fv_r, fv_nxt;
  ifpxc_pkg::frame_t             frame_r, frame_nxt;
  logic                          accept;
  logic [7:0]                    first_byte;
  logic [7:0]                    xor_add;

  assign byte_ready  = !fv_r || frame_ready;
  assign accept      = byte_valid && byte_ready;
  assign frame_valid = fv_r;
  assign frame_data  = frame_r;

  // Store write at the fill position and the per-byte decision
  always_comb begin
    for (int i = 0; i < ifpxc_pkg::FRAME_BYTES; i++) begin
      wr_store[i]  = (fill_r == ifpxc_pkg::FILL_W'(i)) ? byte_data : store_r[i];
      store_nxt[i] = store_r[i];
    end
    first_byte = (fill_r == '0) ? byte_data : store_r[0];
    xor_add    = (fill_r != '0) ? (xor_r ^ byte_data) : xor_r;
    fill_nxt   = fill_r;
    xor_nxt    = xor_r;
    fv_nxt     = fv_r && !frame_ready;
    frame_nxt  = frame_r;
    if (accept) begin
      for (int i = 0; i < ifpxc_pkg::FRAME_BYTES; i++) begin
        store_nxt[i] = wr_store[i];
      end
      if (first_byte != header_value) begin
        // lost sync: start over
        fill_nxt = '0;
        xor_nxt  = '0;
      end else if (fill_r != LAST_IDX) begin
        fill_nxt = fill_r + 1'b1;
        xor_nxt  = xor_add;
      end else if (xor_r != byte_data) begin
        // checksum mismatch: slide window by one byte
        for (int i = 0; i < ifpxc_pkg::FRAME_BYTES - 1; i++) begin
          store_nxt[i] = wr_store[i+1];
        end
        fill_nxt         = LAST_IDX;
        xor_nxt          = xor_add ^ wr_store[1];
        fv_nxt           = 1'b1;
        frame_nxt.status = ifpxc_pkg::STATUS_BAD;
        frame_nxt.raw    = '0;
      end else begin
        // good frame: little-endian samples from bytes 1 .. 2*SAMPLE_COUNT
        fill_nxt         = '0;
        xor_nxt          = '0;
        fv_nxt           = 1'b1;
        frame_nxt.status = ifpxc_pkg::STATUS_GOOD;
        for (int i = 0; i < ifpxc_pkg::SAMPLE_COUNT; i++) begin
          frame_nxt.raw[i] = {wr_store[2*i+2], wr_store[2*i+1]};
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      xor_r  <= '0;
      fv_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      xor_r  <= xor_nxt;
      fv_r   <= fv_nxt;
    end
  end

  // Payload: frame store and frame register
  always_ff @(posedge clk) begin
    for (int i = 0; i < ifpxc_pkg::FRAME_BYTES; i++) begin
      store_r[i] <= store_nxt[i];
    end
    frame_r <= frame_nxt;
  end

endmodule

[rtl/ifpxc_scaler.sv]
// Gain scaler: ten 16x16 signed-by-unsigned products into the result register.
// Depends on ifpxc_pkg. Drives the output stream handshake.
module ifpxc_scaler (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              frame_valid,
  output logic                                              frame_ready,
  input  ifpxc_pkg::frame_t                                 frame_data,
  input  ifpxc_pkg::gains_t                                 gains,
  output logic                                              res_valid,
  input  logic                                              res_ready,
  output logic [ifpxc_pkg::SAMPLE_COUNT*ifpxc_pkg::RESULT_W-1:0] res_data,
  output logic                                              res_status
);

  logic                                                    ov_r, ov_nxt;
  logic [ifpxc_pkg::SAMPLE_COUNT-1:0][ifpxc_pkg::RESULT_W-1:0] prod_r, prod_nxt;
  logic                                                    status_r, status_nxt;
  logic [15:0]                                             gain;
  logic signed [32:0]                                      full_prod;
  logic                                                    load;

  assign frame_ready = !ov_r || res_ready;
  assign load        = frame_valid && frame_ready;
  assign res_valid   = ov_r;
  assign res_data    = prod_r;
  assign res_status  = status_r;

  // One multiplier per sample lane
  always_comb begin
    prod_nxt   = prod_r;
    status_nxt = status_r;
    gain       = '0;
    full_prod  = '0;
    for (int i = 0; i < ifpxc_pkg::SAMPLE_COUNT; i++) begin
      if (i < ifpxc_pkg::ACCEL_END) begin
        gain = gains.accel;
      end else if (i < ifpxc_pkg::GYRO_END) begin
        gain = gains.gyro;
      end else begin
        gain = gains.quat;
      end
      full_prod = $signed(frame_data.raw[i]) * $signed({1'b0, gain});
      if (load) begin
        prod_nxt[i] = full_prod[ifpxc_pkg::RESULT_W-1:0];
      end
    end
    if (load) begin
      status_nxt = frame_data.status;
    end
    ov_nxt = load || (ov_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    status_r <= status_nxt;
  end

endmodule

[sim/imu_frame_checker.sv]
// Watches the byte, result and register channels of the IMU frame parser,
// predicts each frame result and compares it field by field.
// Depends on ifpxc_pkg for widths, register indexes and status codes.
module imu_frame_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [319:0] out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           mismatch_count,
  output int           frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_SLOTS = 32;

  typedef struct packed {
    logic                                                        status;
    logic [ifpxc_pkg::SAMPLE_COUNT-1:0][ifpxc_pkg::RESULT_W-1:0] value;
  } imu_result_t;

  // register shadows
  logic [7:0]         hdr_shadow;
  ifpxc_pkg::gains_t  gains;

  // framing state
  logic [7:0]  frame_buf [BUF_SLOTS];
  int          fill;
  logic [7:0]  xor_acc;

  imu_result_t expected_frames [$];

  string field_name [ifpxc_pkg::SAMPLE_COUNT] = '{"accel_x", "accel_y", "accel_z",
                                                  "gyro_x", "gyro_y", "gyro_z",
                                                  "quat_x", "quat_y", "quat_z",
                                                  "quat_w"};

  // signed raw sample times unsigned Q0.16 gain, low 32 bits
  function automatic logic [ifpxc_pkg::RESULT_W-1:0] scaled_sample(
    input logic [7:0] lo, input logic [7:0] hi, input logic [15:0] gain);
    logic signed [15:0] raw;
    longint             prod;
    raw  = {hi, lo};
    prod = raw * $signed({1'b0, gain});
    return prod[ifpxc_pkg::RESULT_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch %s: expected %h, got %h", $realtime, what, want_v, got_v);
  endtask

  // one received byte through the framer; queues a result when a frame closes
  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0]  sum;
    logic [15:0] gain;
    imu_result_t r;
    frame_buf[fill % BUF_SLOTS] = b;
    if (fill != 0) xor_acc ^= b;
    fill++;
    if (frame_buf[0] != hdr_shadow) begin
      fill    = 0;
      xor_acc = '0;
    end else if (fill >= ifpxc_pkg::FRAME_BYTES) begin
      sum = xor_acc ^ frame_buf[ifpxc_pkg::FRAME_BYTES-1];
      if (sum != frame_buf[ifpxc_pkg::FRAME_BYTES-1]) begin
        // bad checksum: slide the window by one byte
        xor_acc ^= frame_buf[1];
        for (int k = 0; k < BUF_SLOTS-1; k++) frame_buf[k] = frame_buf[k+1];
        frame_buf[BUF_SLOTS-1] = '0;
        fill     = ifpxc_pkg::FRAME_BYTES-1;
        r.status = ifpxc_pkg::STATUS_BAD;
        r.value  = '0;
      end else begin
        r.status = ifpxc_pkg::STATUS_GOOD;
        for (int s = 0; s < ifpxc_pkg::SAMPLE_COUNT; s++) begin
          gain = (s < ifpxc_pkg::ACCEL_END) ? gains.accel :
                 (s < ifpxc_pkg::GYRO_END)  ? gains.gyro  : gains.quat;
          r.value[s] = scaled_sample(frame_buf[2*s+1], frame_buf[2*s+2], gain);
        end
        fill    = 0;
        xor_acc = '0;
      end
      expected_frames = {expected_frames, r};
    end
  endtask

  always @(posedge clk) begin
    imu_result_t got;
    imu_result_t want;
    if (!rst_n) begin
      hdr_shadow     = '0;
      gains          = '0;
      fill           = 0;
      xor_acc        = '0;
      mismatch_count = 0;
      for (int k = 0; k < BUF_SLOTS; k++) frame_buf[k] = '0;
      expected_frames.delete();
    end else begin
      // result word against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.value  = out_tdata;
        if (expected_frames.size() == 0) begin
          note_mismatch("result with none pending, status",
                        32'(ifpxc_pkg::STATUS_GOOD), 32'(got.status));
        end else begin
          want = expected_frames.pop_front();
          if (got.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
          for (int s = 0; s < ifpxc_pkg::SAMPLE_COUNT; s++)
            if (got.value[s] !== want.value[s])
              note_mismatch(field_name[s], want.value[s], got.value[s]);
        end
      end
      // byte word, seen with the registers as they stood before this edge
      if (in_tvalid && in_tready) absorb_byte(in_tdata);
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ifpxc_pkg::CFG_HEADER: hdr_shadow  = cfg_data[7:0];
          ifpxc_pkg::CFG_ACCEL:  gains.accel = cfg_data;
          ifpxc_pkg::CFG_GYRO:   gains.gyro  = cfg_data;
          ifpxc_pkg::CFG_QUAT:   gains.quat  = cfg_data;
          default: ;
        endcase
      end
    end
    frames_pending = expected_frames.size();
  end

endmodule

[sim/tb.sv]
// Top of the IMU frame parser bench: clock, reset, byte and register stimulus,
// receiver back-pressure and the final verdict.
// Depends on ifpxc_pkg, imu_frame_parser_xor_check_unit and imu_frame_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT      = 500_000;
  localparam int         TARGET_BYTES     = 1100;
  localparam int         SEQS_PER_PHASE   = 12;
  localparam int         LONG_HOLD        = 400;
  localparam logic [7:0] CFG_FIRST_UNUSED = ifpxc_pkg::CFG_QUAT + 8'd1;

  typedef logic [ifpxc_pkg::SAMPLE_COUNT-1:0][15:0] sample_set_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [319:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [15:0]  cfg_data;

  int          mismatch_count;
  int          frames_pending;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          hold_cycles = 0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;
  logic [7:0]  cur_header = '0;

  imu_frame_parser_xor_check_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  imu_frame_checker u_frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .frames_pending (frames_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // register write; caller drops cfg_valid after the last one
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // one byte word; tvalid stays high across back-to-back words
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // header, ten samples, XOR byte; optionally corrupted, header repeated in byte 1, or cut short
  task automatic send_frame(input sample_set_t samples, input bit corrupt,
                            input bit header_inside, input int cut);
    logic [7:0] body [ifpxc_pkg::FRAME_BYTES];
    logic [7:0] sum;
    body[0] = cur_header;
    for (int s = 0; s < ifpxc_pkg::SAMPLE_COUNT; s++) begin
      body[2*s+1] = samples[s][7:0];
      body[2*s+2] = samples[s][15:8];
    end
    if (header_inside) body[1] = cur_header;
    sum = '0;
    for (int k = 1; k < ifpxc_pkg::FRAME_BYTES-1; k++) sum ^= body[k];
    body[ifpxc_pkg::FRAME_BYTES-1] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
    for (int k = 0; k < cut; k++) push_byte(body[k]);
  endtask

  // samples biased toward the int16 corners
  function automatic sample_set_t draw_samples();
    sample_set_t v;
    for (int s = 0; s < ifpxc_pkg::SAMPLE_COUNT; s++) begin
      case ($urandom_range(0, 7))
        0:       v[s] = 16'h8000;
        1:       v[s] = 16'h7FFF;
        2:       v[s] = 16'hFFFF;
        3:       v[s] = 16'h0000;
        default: v[s] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] draw_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // wait for every predicted result plus the pipeline depth
  task automatic drain();
    in_tvalid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver: random stall before each result, one long hold on request
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = take_steady ? 0 : $urandom_range(0, 17);
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    int          phase;
    int          pick;
    logic [7:0]  hdr;
    logic [15:0] ga, gg, gq;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: byte extremes as junk, then one good frame of corner samples
    cur_header = 8'hA5;
    write_reg(ifpxc_pkg::CFG_HEADER, 16'h00A5);
    write_reg(ifpxc_pkg::CFG_ACCEL, 16'hFFFF);
    write_reg(ifpxc_pkg::CFG_GYRO, 16'h0001);
    write_reg(ifpxc_pkg::CFG_QUAT, 16'h8000);
    cfg_valid <= 1'b0;
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame({16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF, 16'h8001,
                16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b0, 1'b0,
               ifpxc_pkg::FRAME_BYTES);

    // random phases, each with fresh register settings
    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      drain();
      case (phase)
        0: begin
          hdr = 8'h00; ga = 16'h0000; gg = 16'h0000; gq = 16'h0000;
        end
        1: begin
          hdr = 8'hFF; ga = 16'hFFFF; gg = 16'hFFFF; gq = 16'hFFFF;
        end
        default: begin
          hdr = 8'($urandom); ga = draw_gain(); gg = draw_gain(); gq = draw_gain();
        end
      endcase
      // a leftover partial frame meets the new header here
      cur_header = hdr;
      write_reg(ifpxc_pkg::CFG_HEADER, {8'($urandom), hdr});
      write_reg(ifpxc_pkg::CFG_ACCEL, ga);
      write_reg(ifpxc_pkg::CFG_GYRO, gg);
      write_reg(ifpxc_pkg::CFG_QUAT, gq);
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_FIRST_UNUSED + 8'($urandom_range(0, 251)), 16'($urandom));
      cfg_valid <= 1'b0;

      send_steady = ($urandom_range(0, 3) == 0);
      take_steady = ($urandom_range(0, 3) == 0);
      // back-pressure phase: receiver holds off while frames keep coming
      if (phase == 2) begin
        hold_cycles = LONG_HOLD;
        send_steady = 1'b1;
      end

      for (int n = 0; n < SEQS_PER_PHASE; n++) begin
        if (bytes_sent >= TARGET_BYTES) break;
        pick = (phase == 2) ? 0 : $urandom_range(0, 19);
        if (pick < 12)
          send_frame(draw_samples(), 1'b0, 1'b0, ifpxc_pkg::FRAME_BYTES);
        else if (pick < 15)
          send_frame(draw_samples(), 1'b1, 1'b0, ifpxc_pkg::FRAME_BYTES);
        else if (pick < 16)
          send_frame(draw_samples(), 1'b1, 1'b1, ifpxc_pkg::FRAME_BYTES);
        else if (pick < 18)
          send_frame(draw_samples(), 1'b0, 1'b0,
                     $urandom_range(1, ifpxc_pkg::FRAME_BYTES-1));
        else
          repeat ($urandom_range(1, 6))
            push_byte(($urandom_range(0, 3) == 0) ? cur_header : 8'($urandom));
      end
      // odd phases end mid-frame
      if (phase % 2 == 1)
        send_frame(draw_samples(), 1'b0, 1'b0,
                   $urandom_range(1, ifpxc_pkg::FRAME_BYTES-1));
      phase++;
    end

    drain();
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
